FILE: rtl/daily_minute_activity_histogram_defines.svh
// Assertion helpers shared by the histogram RTL.
`ifndef DAILY_MINUTE_ACTIVITY_HISTOGRAM_DEFINES_SVH
`define DAILY_MINUTE_ACTIVITY_HISTOGRAM_DEFINES_SVH

// Check that cons holds in every cycle in which ante holds.
`define DMAH_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond never holds.
`define DMAH_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/dmah_pkg.sv
`timescale 1ns / 1ps

package dmah_pkg;

  // Default geometry of the histogram
  localparam int unsigned PERIOD_SECONDS_DEF = 86400;
  localparam int unsigned NUM_BINS_DEF       = 1440;
  localparam int unsigned BIN_SECONDS_DEF    = 60;
  localparam int unsigned COUNT_WIDTH_DEF    = 32;

  // Fixed field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned INDEX_W = 11;

  // Command queue between front and back, power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    FUNC_RECORD = 1'b0,
    FUNC_READ   = 1'b1
  } func_e;

  // Classified command as it travels through the queue
  typedef struct packed {
    logic               is_read;
    logic [TIME_W-1:0]  event_time;
    logic [INDEX_W-1:0] bin_index;
    logic               index_ok;
    logic [TIME_W-1:0]  index_offset;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/dmah_ram.sv
`timescale 1ns / 1ps

module dmah_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1440,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/dmah_front.sv
`timescale 1ns / 1ps

module dmah_front #(
  parameter int unsigned NUM_BINS    = dmah_pkg::NUM_BINS_DEF,
  parameter int unsigned BIN_SECONDS = dmah_pkg::BIN_SECONDS_DEF
) (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [dmah_pkg::TIME_W-1:0]  event_time_i,
  input  logic [dmah_pkg::INDEX_W-1:0] bin_index_i,
  input  dmah_pkg::q_status_t          q_status_i,
  output logic                         push_o,
  output dmah_pkg::cmd_t               cmd_o
);

  localparam logic [dmah_pkg::TIME_W-1:0] NumBinsT = dmah_pkg::TIME_W'(NUM_BINS);
  localparam logic [dmah_pkg::TIME_W-1:0] BinSecT  = dmah_pkg::TIME_W'(BIN_SECONDS);

  // Stall only on a full queue
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i & ~q_status_i.full;

  // Decode and precompute the state-free parts of a read
  always_comb begin
    cmd_o.is_read      = (dmah_pkg::func_e'(func_i) == dmah_pkg::FUNC_READ);
    cmd_o.event_time   = event_time_i;
    cmd_o.bin_index    = bin_index_i;
    cmd_o.index_ok     = dmah_pkg::TIME_W'(bin_index_i) < NumBinsT;
    cmd_o.index_offset = dmah_pkg::TIME_W'(bin_index_i) * BinSecT;
  end

endmodule

FILE: rtl/dmah_queue.sv
`timescale 1ns / 1ps
`include "daily_minute_activity_histogram_defines.svh"

module dmah_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dmah_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output dmah_pkg::q_status_t status_o,
  output dmah_pkg::cmd_t      head_o
);

  localparam int unsigned PW = (dmah_pkg::QUEUE_DEPTH > 1) ? $clog2(dmah_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(dmah_pkg::QUEUE_DEPTH + 1);

  dmah_pkg::cmd_t mem_q [dmah_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CW'(dmah_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

  `DMAH_ASSERT_IMP(a_pop_not_empty, clk_i, rst_ni, pop_i, !status_o.empty, "pop from empty queue")
  `DMAH_ASSERT_IMP(a_push_not_full, clk_i, rst_ni, push_i, !status_o.full, "push into full queue")

endmodule

FILE: rtl/dmah_back.sv
`timescale 1ns / 1ps
`include "daily_minute_activity_histogram_defines.svh"

module dmah_back #(
  parameter int unsigned PERIOD_SECONDS = dmah_pkg::PERIOD_SECONDS_DEF,
  parameter int unsigned NUM_BINS       = dmah_pkg::NUM_BINS_DEF,
  parameter int unsigned BIN_SECONDS    = dmah_pkg::BIN_SECONDS_DEF,
  parameter int unsigned COUNT_WIDTH    = dmah_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dmah_pkg::TIME_W-1:0] cfg_wdata_i,
  input  dmah_pkg::q_status_t         q_status_i,
  input  dmah_pkg::cmd_t              head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        counted_o,
  output logic                        wrapped_o,
  output logic [dmah_pkg::TIME_W-1:0] bin_count_o,
  output logic [dmah_pkg::TIME_W-1:0] bin_start_time_o
);

  localparam int unsigned TW    = dmah_pkg::TIME_W;
  localparam int unsigned AW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned OFF_W = $clog2(PERIOD_SECONDS);

  localparam logic [TW-1:0] PeriodT  = TW'(PERIOD_SECONDS);
  localparam logic [TW-1:0] BinSecT  = TW'(BIN_SECONDS);
  localparam logic [TW-1:0] NumBinsT = TW'(NUM_BINS);

  // Reciprocal of the period, scaled by 2^32
  localparam logic [63:0] M1Full = (64'd1 << 32) / 64'(PERIOD_SECONDS);
  localparam int unsigned M1W    = (M1Full > 0) ? $clog2(M1Full + 1) : 1;
  localparam logic [M1W-1:0] M1  = M1W'(M1Full);

  // Reciprocal of the bin width, scaled by 2^OFF_W
  localparam logic [63:0] M2Full = (64'd1 << OFF_W) / 64'(BIN_SECONDS);
  localparam int unsigned M2W    = (M2Full > 0) ? $clog2(M2Full + 1) : 1;
  localparam logic [M2W-1:0] M2  = M2W'(M2Full);

  typedef enum logic [10:0] {
    ST_CLEAR   = 11'b000_0000_0001,
    ST_IDLE    = 11'b000_0000_0010,
    ST_DIV_MUL = 11'b000_0000_0100,
    ST_DIV_SUB = 11'b000_0000_1000,
    ST_DIV_FIX = 11'b000_0001_0000,
    ST_BIN_MUL = 11'b000_0010_0000,
    ST_BIN_FIX = 11'b000_0100_0000,
    ST_DECIDE  = 11'b000_1000_0000,
    ST_MEM_UPD = 11'b001_0000_0000,
    ST_RD_DATA = 11'b010_0000_0000,
    ST_RESULT  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]    clr_cnt_q;
  logic             clr_resume_q;
  logic [TW-1:0]    begin_q, end_q, last_req_q;
  logic [OFF_W-1:0] last_off_q;
  logic             last_off_valid_q;

  dmah_pkg::cmd_t   cmd_q;
  logic [TW-1:0]    diff_q;
  logic [M1W-1:0]   q1_q;
  logic [OFF_W:0]   rem_q;
  logic [OFF_W-1:0] off_q;
  logic [M2W-1:0]   q2_q, bin_q;
  logic             cnt_ok_q, counted_q, wrapped_q;
  logic [TW-1:0]    count_q, start_q;

  logic             out_valid_q, out_counted_q, out_wrapped_q;
  logic [TW-1:0]    out_count_q, out_start_q;

  logic                   rec_take, rec_wrap, clr_last, cnt_ok, load_out;
  logic [TW+M1W-1:0]      prod1;
  logic [TW-1:0]          prod_qp;
  logic [OFF_W+M2W-1:0]   prod2;
  logic [OFF_W-1:0]       r2;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata, sat_inc;

  assign pop_o    = (state_q == ST_IDLE) & ~q_status_i.empty;
  assign rec_take = ~head_i.is_read & (head_i.event_time != last_req_q)
                  & (head_i.event_time >= begin_q);
  assign rec_wrap = head_i.event_time > end_q;
  assign clr_last = (clr_cnt_q == AW'(NUM_BINS - 1));
  assign load_out = (state_q == ST_RESULT) & (~out_valid_q | ~out_stall_i);

  // Offset modulo the period: estimate quotient, multiply back, fix once
  assign prod1   = (TW + M1W)'(diff_q) * (TW + M1W)'(M1);
  assign prod_qp = TW'(q1_q) * PeriodT;
  assign prod2   = (OFF_W + M2W)'(off_q) * (OFF_W + M2W)'(M2);
  assign r2      = OFF_W'(TW'(off_q) - TW'(q2_q) * BinSecT);
  assign cnt_ok  = ~(last_off_valid_q & (off_q == last_off_q)) & (TW'(bin_q) < NumBinsT);

  assign sat_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);

  always_comb begin
    ram_we    = (state_q == ST_CLEAR) | (state_q == ST_MEM_UPD);
    ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : AW'(bin_q);
    ram_wdata = (state_q == ST_CLEAR) ? '0 : (wrapped_q ? COUNT_WIDTH'(1) : sat_inc);
    if (state_q == ST_IDLE) begin
      ram_raddr = head_i.index_ok ? AW'(head_i.bin_index) : '0;
    end else begin
      ram_raddr = AW'(bin_q);
    end
  end

  dmah_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          if (clr_resume_q) begin
            state_d = cnt_ok_q ? ST_MEM_UPD : ST_RESULT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (pop_o) begin
          if (head_i.is_read) begin
            state_d = ST_RD_DATA;
          end else begin
            state_d = rec_take ? ST_DIV_MUL : ST_RESULT;
          end
        end
      end
      ST_DIV_MUL: state_d = ST_DIV_SUB;
      ST_DIV_SUB: state_d = ST_DIV_FIX;
      ST_DIV_FIX: state_d = ST_BIN_MUL;
      ST_BIN_MUL: state_d = ST_BIN_FIX;
      ST_BIN_FIX: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (wrapped_q) begin
          state_d = ST_CLEAR;
        end else begin
          state_d = cnt_ok ? ST_MEM_UPD : ST_RESULT;
        end
      end
      ST_MEM_UPD: state_d = ST_RESULT;
      ST_RD_DATA: state_d = ST_RESULT;
      ST_RESULT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
    if (cfg_we_i) begin
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_CLEAR;
      clr_cnt_q        <= '0;
      clr_resume_q     <= 1'b0;
      begin_q          <= '0;
      end_q            <= PeriodT;
      last_req_q       <= '0;
      last_off_q       <= '0;
      last_off_valid_q <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load_out | (out_valid_q & out_stall_i);
      if (cfg_we_i) begin
        begin_q          <= cfg_wdata_i;
        end_q            <= cfg_wdata_i + PeriodT;
        last_req_q       <= '0;
        last_off_q       <= '0;
        last_off_valid_q <= 1'b0;
        clr_cnt_q        <= '0;
        clr_resume_q     <= 1'b0;
      end else begin
        if (state_q == ST_CLEAR) begin
          clr_cnt_q <= clr_last ? '0 : clr_cnt_q + AW'(1);
          if (clr_last) begin
            clr_resume_q <= 1'b0;
          end
        end
        if (pop_o && rec_take) begin
          last_req_q <= head_i.event_time;
          if (rec_wrap) begin
            begin_q          <= end_q;
            end_q            <= end_q + PeriodT;
            last_off_valid_q <= 1'b0;
          end
        end
        if (state_q == ST_DECIDE) begin
          if (cnt_ok) begin
            last_off_q       <= off_q;
            last_off_valid_q <= 1'b1;
          end
          if (wrapped_q) begin
            clr_resume_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q     <= head_i;
      counted_q <= 1'b0;
      wrapped_q <= rec_take & rec_wrap;
      count_q   <= '0;
      start_q   <= '0;
      diff_q    <= head_i.event_time - (rec_wrap ? end_q : begin_q);
    end
    case (state_q)
      ST_DIV_MUL: q1_q  <= prod1[TW+M1W-1:TW];
      ST_DIV_SUB: rem_q <= (OFF_W + 1)'(diff_q - prod_qp);
      ST_DIV_FIX: begin
        if (TW'(rem_q) >= PeriodT) begin
          off_q <= OFF_W'(TW'(rem_q) - PeriodT);
        end else begin
          off_q <= OFF_W'(rem_q);
        end
      end
      ST_BIN_MUL: q2_q <= prod2[OFF_W+M2W-1:OFF_W];
      ST_BIN_FIX: bin_q <= (TW'(r2) >= BinSecT) ? q2_q + M2W'(1) : q2_q;
      ST_DECIDE: begin
        cnt_ok_q  <= cnt_ok;
        counted_q <= cnt_ok;
      end
      ST_RD_DATA: begin
        count_q <= cmd_q.index_ok ? TW'(ram_rdata) : '0;
        start_q <= begin_q + cmd_q.index_offset;
      end
      default: ;
    endcase
    if (load_out) begin
      out_counted_q <= counted_q;
      out_wrapped_q <= wrapped_q;
      out_count_q   <= count_q;
      out_start_q   <= start_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign counted_o        = out_counted_q;
  assign wrapped_o        = out_wrapped_q;
  assign bin_count_o      = out_count_q;
  assign bin_start_time_o = out_start_q;

  `DMAH_ASSERT_NEVER(a_no_pop_in_clear, clk_i, rst_ni, (state_q == ST_CLEAR) && pop_o, "item taken during bin clear")
  `DMAH_ASSERT_IMP(a_bin_write_range, clk_i, rst_ni, ram_we, TW'(ram_waddr) < NumBinsT, "bin write out of range")
  `DMAH_ASSERT_IMP(a_out_slot_free, clk_i, rst_ni, load_out, !out_valid_q || !out_stall_i, "result overwritten")

endmodule

FILE: rtl/daily_minute_activity_histogram.sv
`timescale 1ns / 1ps
// Per-minute activity histogram over a rolling one-period window.
// Input channel (in_valid_i / in_stall_o): func_i = 0 records an event at
// event_time_i, func_i = 1 reads bin bin_index_i. A transfer happens when
// valid is high and stall is low. Every item gives exactly one result on the
// output channel (out_valid_o / out_stall_i).
// Config: cfg_we_i loads window_start from cfg_wdata_i, resets the window and
// starts a clear of all bins; write it only while no item is in flight.
// Steps per item: a read fetches its bin from the bin memory; an ignored
// record goes straight to the result; a taken record runs the modulo and bin
// index steps and, when it reaches a bin, a read-modify-write of that bin; a
// record that advances the window also sweeps all bins to zero before that.
// The back-end sequencer handles one item at a time and takes the next item
// only after the current result is loaded. The reciprocal-multiply modulo and
// the bin memory read-modify-write set the time a record takes.
// A two-entry queue lets two items transfer in while the back end is busy.
// Reset: a clearing pass over all NUM_BINS bins runs before the first item is
// executed; items still queue during it.
// A stalled result waits in the output register; the back end holds its
// next result until that slot frees, and input stalls once the queue fills.

module daily_minute_activity_histogram #(
  parameter int unsigned PERIOD_SECONDS = dmah_pkg::PERIOD_SECONDS_DEF,
  parameter int unsigned NUM_BINS       = dmah_pkg::NUM_BINS_DEF,
  parameter int unsigned BIN_SECONDS    = dmah_pkg::BIN_SECONDS_DEF,
  parameter int unsigned COUNT_WIDTH    = dmah_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dmah_pkg::TIME_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [dmah_pkg::TIME_W-1:0]  event_time_i,
  input  logic [dmah_pkg::INDEX_W-1:0] bin_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         counted_o,
  output logic                         wrapped_o,
  output logic [dmah_pkg::TIME_W-1:0]  bin_count_o,
  output logic [dmah_pkg::TIME_W-1:0]  bin_start_time_o
);

  dmah_pkg::q_status_t q_status;
  dmah_pkg::cmd_t      push_cmd, head_cmd;
  logic                push, pop;

  // Front: classify the item and precompute the read offset
  dmah_front #(
    .NUM_BINS    (NUM_BINS),
    .BIN_SECONDS (BIN_SECONDS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .event_time_i (event_time_i),
    .bin_index_i  (bin_index_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Decouple acceptance from execution
  dmah_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .status_o (q_status),
    .head_o   (head_cmd)
  );

  // Back: window state, modulo datapath, bin memory and result register
  dmah_back #(
    .PERIOD_SECONDS (PERIOD_SECONDS),
    .NUM_BINS       (NUM_BINS),
    .BIN_SECONDS    (BIN_SECONDS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .q_status_i       (q_status),
    .head_i           (head_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .counted_o        (counted_o),
    .wrapped_o        (wrapped_o),
    .bin_count_o      (bin_count_o),
    .bin_start_time_o (bin_start_time_o)
  );

endmodule
